// ===== src/too_pkg.sv =====
package too_pkg;

  // Field and register widths
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned TS_W    = 7;
  localparam int unsigned TA_W    = 8;
  localparam int unsigned TD_W    = 9;
  localparam int unsigned LW_W    = 14;
  localparam int unsigned COL_W   = 13;
  localparam int unsigned ROW_W   = 14;
  localparam int unsigned IDX_W   = 15;
  localparam int unsigned CFG_W   = 14;

  // Fixed limits of the frame geometry
  localparam int unsigned MaxTilesDown = 256;
  localparam int unsigned MaxLineWidth = 8192;

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'd255;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_TILE_SIZE    = 2'd0,
    CFG_TILES_ACROSS = 2'd1,
    CFG_TILES_DOWN   = 2'd2,
    CFG_LINE_WIDTH   = 2'd3
  } too_cfg_e;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               frame_start;
  } too_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] tile_index;
    logic             tile_free;
    logic             last_tile;
  } too_out_t;

endpackage

// ===== src/too_ram.sv =====
module too_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/too_div.sv =====
module too_div import too_pkg::*; #(
  parameter int unsigned DW = 14
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DW-1:0]   dividend_i,
  input  logic [TS_W-1:0] divisor_i,
  output logic            busy_o,
  output logic [DW-1:0]   quot_o,
  output logic [TS_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0]   cnt_q;
  logic [DW-1:0]   quo_q;
  logic [TS_W-1:0] rem_q;
  logic [TS_W:0]   trial;
  logic [TS_W:0]   diff;
  logic            ge;

  // One quotient bit per cycle: shift the next dividend bit into the remainder
  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(DW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
    end
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/tile_occupancy_from_alpha.sv =====
// Channel | Direction | Payload   | Handshake
// --------+-----------+-----------+-------------------------------------
// in      | input     | too_in_t  | in_valid_i / in_ready_o
// out     | output    | too_out_t | out_valid_o / out_ready_i
// cfg     | input     | 14 bits   | cfg_we_i, cfg_idx_i (write only)
//
// One pixel per cycle while in_ready_o is high; a result passes through the flag
// stage and the output register. The flag RAM read-modify-write spans the input
// and flag stages, with a one-entry bypass. A tile_size write holds in_ready_o low
// while the position counters are re-split into tile and offset by bit-serial dividers.
// Reset clears counters and control; the flag RAM is not cleared.
// A stalled output holds the flag stage; the input stalls behind it and during a re-split.
module tile_occupancy_from_alpha import too_pkg::*; #(
  parameter int unsigned MAX_TILES_ACROSS = 128,
  parameter int unsigned MAX_TILE_SIZE    = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  too_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output too_out_t         out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;

  // Configuration registers
  logic [TS_W-1:0] tile_size_q;
  logic [TA_W-1:0] tiles_across_q;
  logic [TD_W-1:0] tiles_down_q;
  logic [LW_W-1:0] line_width_q;

  // Effective (clamped) configuration
  logic [TS_W-1:0] ts_eff;
  logic [TA_W-1:0] ta_eff;
  logic [TD_W-1:0] td_eff;
  logic [LW_W-1:0] lw_eff;

  // Position counters
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] tx_q, tx_d;
  logic [ROW_W-1:0] ty_q, ty_d;
  logic [TS_W-1:0]  xin_q, xin_d;
  logic [TS_W-1:0]  yin_q, yin_d;

  // Current pixel position
  logic [COL_W-1:0] col_cur, tx_cur;
  logic [ROW_W-1:0] row_cur, ty_cur;
  logic [TS_W-1:0]  xin_cur, yin_cur;

  logic [LW_W-1:0]  col_inc;
  logic [ROW_W-1:0] row_inc;
  logic [TS_W-1:0]  xin_inc, yin_inc;
  logic             line_wrap;

  logic             in_area;
  logic             corner;
  logic             first_px;
  logic             clear_px;
  logic             last_px;
  logic [15:0]      prod;
  logic [15:0]      idx_sum;
  logic [AW-1:0]    slot;

  // Flag stage
  logic             s1_valid_q, s1_valid_d;
  logic             s1_emit_q;
  logic             s1_first_q;
  logic             s1_clear_q;
  logic             s1_last_q;
  logic [AW-1:0]    s1_slot_q;
  logic [IDX_W-1:0] s1_index_q;
  logic             s1_adv;
  logic             s1_fire;

  // Bypass of the last flag write
  logic             bp_valid_q;
  logic [AW-1:0]    bp_slot_q;
  logic             bp_flag_q;

  logic             rd_flag;
  logic             flag_old;
  logic             flag_new;

  // Output register
  logic             out_valid_q, out_valid_d;
  too_out_t         out_data_q;
  logic             out_load;

  logic             in_fire;

  // Re-split of the counters after a tile size change
  logic             start_q;
  logic             recalc_q;
  logic             col_busy, row_busy;
  logic [COL_W-1:0] col_quot;
  logic [ROW_W-1:0] row_quot;
  logic [TS_W-1:0]  col_rem, row_rem;
  logic             recalc_done;
  logic             ts_write;

  // Clamp the registers to their legal ranges
  always_comb begin
    if (tile_size_q == '0) begin
      ts_eff = TS_W'(1);
    end else if (32'(tile_size_q) > MAX_TILE_SIZE) begin
      ts_eff = TS_W'(MAX_TILE_SIZE);
    end else begin
      ts_eff = tile_size_q;
    end
    if (tiles_across_q == '0) begin
      ta_eff = TA_W'(1);
    end else if (32'(tiles_across_q) > MAX_TILES_ACROSS) begin
      ta_eff = TA_W'(MAX_TILES_ACROSS);
    end else begin
      ta_eff = tiles_across_q;
    end
    if (tiles_down_q == '0) begin
      td_eff = TD_W'(1);
    end else if (32'(tiles_down_q) > MaxTilesDown) begin
      td_eff = TD_W'(MaxTilesDown);
    end else begin
      td_eff = tiles_down_q;
    end
    if (line_width_q == '0) begin
      lw_eff = LW_W'(1);
    end else if (32'(line_width_q) > MaxLineWidth) begin
      lw_eff = LW_W'(MaxLineWidth);
    end else begin
      lw_eff = line_width_q;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q    <= TS_W'(8);
      tiles_across_q <= TA_W'(28);
      tiles_down_q   <= TD_W'(31);
      line_width_q   <= LW_W'(224);
    end else if (cfg_we_i) begin
      unique case (too_cfg_e'(cfg_idx_i))
        CFG_TILE_SIZE:    tile_size_q    <= cfg_wdata_i[TS_W-1:0];
        CFG_TILES_ACROSS: tiles_across_q <= cfg_wdata_i[TA_W-1:0];
        CFG_TILES_DOWN:   tiles_down_q   <= cfg_wdata_i[TD_W-1:0];
        CFG_LINE_WIDTH:   line_width_q   <= cfg_wdata_i[LW_W-1:0];
        default:          tile_size_q    <= tile_size_q;
      endcase
    end
  end

  assign ts_write    = cfg_we_i && (too_cfg_e'(cfg_idx_i) == CFG_TILE_SIZE);
  assign recalc_done = recalc_q && !start_q && !col_busy && !row_busy;

  // Start the dividers in the cycle after the write, hold input until done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 1'b0;
      recalc_q <= 1'b0;
    end else begin
      start_q <= ts_write;
      if (ts_write) begin
        recalc_q <= 1'b1;
      end else if (recalc_done) begin
        recalc_q <= 1'b0;
      end
    end
  end

  too_div #(.DW(COL_W)) u_col_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (col_q),
    .divisor_i  (ts_eff),
    .busy_o     (col_busy),
    .quot_o     (col_quot),
    .rem_o      (col_rem)
  );

  too_div #(.DW(ROW_W)) u_row_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (row_q),
    .divisor_i  (ts_eff),
    .busy_o     (row_busy),
    .quot_o     (row_quot),
    .rem_o      (row_rem)
  );

  // Handshake
  assign s1_adv     = !(s1_valid_q && s1_emit_q && out_valid_q && !out_ready_i);
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !recalc_q && s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Position of this pixel; a frame start restarts at the origin
  always_comb begin
    if (in_data_i.frame_start) begin
      col_cur = '0;
      row_cur = '0;
      tx_cur  = '0;
      ty_cur  = '0;
      xin_cur = '0;
      yin_cur = '0;
    end else begin
      col_cur = col_q;
      row_cur = row_q;
      tx_cur  = tx_q;
      ty_cur  = ty_q;
      xin_cur = xin_q;
      yin_cur = yin_q;
    end
  end

  // Classify the pixel inside its tile
  assign in_area  = (tx_cur < COL_W'(ta_eff)) && (ty_cur < ROW_W'(td_eff)) &&
                    ({1'b0, col_cur} < lw_eff);
  assign first_px = (xin_cur == '0) && (yin_cur == '0);
  assign corner   = (xin_cur == ts_eff - 1'b1) && (yin_cur == ts_eff - 1'b1);
  assign clear_px = in_data_i.alpha != ALPHA_OPAQUE;
  assign last_px  = (tx_cur == COL_W'(ta_eff - 1'b1)) &&
                    (ty_cur == ROW_W'(td_eff - 1'b1));
  assign prod     = ty_cur[7:0] * ta_eff;
  assign idx_sum  = prod + 16'(tx_cur);
  assign slot     = tx_cur[AW-1:0];

  // Advance the counters
  assign col_inc   = {1'b0, col_cur} + 1'b1;
  assign row_inc   = row_cur + 1'b1;
  assign xin_inc   = xin_cur + 1'b1;
  assign yin_inc   = yin_cur + 1'b1;
  assign line_wrap = col_inc >= lw_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    tx_d  = tx_q;
    ty_d  = ty_q;
    xin_d = xin_q;
    yin_d = yin_q;
    if (recalc_done) begin
      tx_d  = col_quot;
      xin_d = col_rem;
      ty_d  = row_quot;
      yin_d = row_rem;
    end else if (in_fire) begin
      row_d = row_cur;
      ty_d  = ty_cur;
      yin_d = yin_cur;
      if (line_wrap) begin
        col_d = '0;
        tx_d  = '0;
        xin_d = '0;
        row_d = row_inc;
        if (row_inc == '0) begin
          ty_d  = '0;
          yin_d = '0;
        end else if (yin_inc == ts_eff) begin
          ty_d  = ty_cur + 1'b1;
          yin_d = '0;
        end else begin
          yin_d = yin_inc;
        end
      end else begin
        col_d = col_inc[COL_W-1:0];
        if (xin_inc == ts_eff) begin
          tx_d  = tx_cur + 1'b1;
          xin_d = '0;
        end else begin
          tx_d  = tx_cur;
          xin_d = xin_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      tx_q  <= '0;
      ty_q  <= '0;
      xin_q <= '0;
      yin_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      tx_q  <= tx_d;
      ty_q  <= ty_d;
      xin_q <= xin_d;
      yin_q <= yin_d;
    end
  end

  // Flag stage: control
  always_comb begin
    if (in_fire) begin
      s1_valid_d = in_area;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_emit_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_fire) begin
        s1_emit_q <= corner;
      end
    end
  end

  // Flag stage: payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_first_q <= first_px;
      s1_clear_q <= clear_px;
      s1_last_q  <= last_px;
      s1_slot_q  <= slot;
      s1_index_q <= idx_sum[IDX_W-1:0];
    end
  end

  too_ram #(.WIDTH(1), .DEPTH(MAX_TILES_ACROSS)) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_slot_q),
    .wdata_i (flag_new),
    .re_i    (in_fire),
    .raddr_i (slot),
    .rdata_o (rd_flag)
  );

  // Merge the pixel into the running column flag
  assign flag_old = (bp_valid_q && (bp_slot_q == s1_slot_q)) ? bp_flag_q : rd_flag;
  assign flag_new = s1_first_q ? s1_clear_q : (flag_old & s1_clear_q);

  // Hold the last write for a read that missed it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_valid_q <= 1'b0;
    end else if (s1_fire) begin
      bp_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      bp_slot_q <= s1_slot_q;
      bp_flag_q <= flag_new;
    end
  end

  // Output register
  assign out_load = s1_fire && s1_emit_q;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.tile_index <= s1_index_q;
      out_data_q.tile_free  <= flag_new;
      out_data_q.last_tile  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== src/too_chk.sv =====
module too_chk import too_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input too_out_t   out_data_o,
  input logic       cfg_we_i,
  input logic [1:0] cfg_idx_i
);

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // A fresh result follows a pixel transfer through the flag stage and output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a preceding pixel transfer");

  // Block input while the counters are re-split after a tile size write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == CFG_TILE_SIZE) |=> !in_ready_o)
    else $error("input taken during counter re-split");

endmodule

bind tile_occupancy_from_alpha too_chk u_too_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i)
);
